/* hdl/atrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_pkg: shared constants for the accelerometer tilt block
// Field widths, datapath widths, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package atrp_pkg;

   localparam int AXIS_W     = 16;   // raw axis and offset width
   localparam int CORR_W     = 17;   // corrected axis width
   localparam int SQ_W       = 32;   // square of a corrected axis
   localparam int SUM_W      = 33;   // sum of two squares
   localparam int ANGLE_W    = 15;   // output angle width

   localparam int SQRT_PRE   = 28;   // radicand is the sum times 2^SQRT_PRE
   localparam int RAD_W      = 34;   // sum padded to an even width
   localparam int ROOT_W     = 31;   // root of the scaled sum
   localparam int REM_W      = 35;   // partial remainder of the root

   localparam int NORM_W     = 41;   // magnitude tracked while normalizing
   localparam int NORM_STEPS = 5;    // shifts of 16, 8, 4, 2, 1
   localparam int VEC_W      = 44;   // CORDIC vector width, signed
   localparam int VY_SHIFT   = 14;   // numerator scale of 16384

   localparam int ACC_FRAC   = 20;   // angle accumulator fraction bits
   localparam int ACC_W      = 28;   // angle accumulator width, signed
   localparam int TAB_LEN    = 24;
   localparam int TAB_W      = 27;
   localparam int CAP_DEG    = 90;

   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 7;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Y = 2'd1,
      CSR_OFFSET_Z = 2'd2
   } csr_index_type;

   localparam logic signed [AXIS_W-1:0] OFFSET_X_RST = 16'sd3416;
   localparam logic signed [AXIS_W-1:0] OFFSET_Y_RST = 16'sd424;
   localparam logic signed [AXIS_W-1:0] OFFSET_Z_RST = 16'sd2532;

   // atan(2^-i) in degrees with ACC_FRAC fraction bits, rounded
   localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
      27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
      27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
      27'd234682,   27'd117342,   27'd58671,    27'd29335,
      27'd14668,    27'd7334,     27'd3667,     27'd1833,
      27'd917,      27'd458,      27'd229,      27'd115,
      27'd57,       27'd29,       27'd14,       27'd7
   };

endpackage

/* hdl/atrp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_if: sample and angle channels
// Valid/ready channels carrying one accelerometer sample or one angle pair.
// ----------------------------------------------------------------------------
interface atrp_req_if import atrp_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [AXIS_W-1:0] accel_x;
   logic signed [AXIS_W-1:0] accel_y;
   logic signed [AXIS_W-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

interface atrp_rsp_if import atrp_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] roll_angle;
   logic signed [ANGLE_W-1:0] pitch_angle;

   modport source (output valid, output roll_angle, output pitch_angle,
                   input ready);
   modport sink   (input valid, input roll_angle, input pitch_angle,
                   output ready);
endinterface

/* hdl/atrp_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_isqrt: pipelined integer square root
// One root bit per stage of floor(sqrt(sum * 2^28)); sideband travels along.
// ----------------------------------------------------------------------------
module atrp_isqrt import atrp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     valid_in,
   input  logic [SUM_W-1:0]         sum_in,
   input  logic signed [CORR_W-1:0] num_in,
   output logic                     valid_out,
   output logic [ROOT_W-1:0]        root_out,
   output logic signed [CORR_W-1:0] num_out,
   output logic                     zero_out
);

   logic                     valid_ff [ROOT_W];
   logic [RAD_W-1:0]         rad_ff   [ROOT_W];
   logic [REM_W-1:0]         rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]        root_ff  [ROOT_W];
   logic signed [CORR_W-1:0] num_ff   [ROOT_W];
   logic                     zero_ff  [ROOT_W];

   genvar j;
   generate
      for (j = 0; j < ROOT_W; j++) begin : g_stage
         localparam int K = ROOT_W - 1 - j;
         logic                     valid_prev;
         logic [RAD_W-1:0]         rad_prev;
         logic [REM_W-1:0]         rem_prev;
         logic [ROOT_W-1:0]        root_prev;
         logic signed [CORR_W-1:0] num_prev;
         logic                     zero_prev;
         logic [1:0]               pair;
         logic [REM_W-1:0]         rem_sh;
         logic [REM_W-1:0]         trial;
         logic [REM_W-1:0]         rem_in;
         logic [ROOT_W-1:0]        root_in;

         if (j == 0) begin : g_first
            assign valid_prev = valid_in;
            assign rad_prev   = {{(RAD_W-SUM_W){1'b0}}, sum_in};
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign num_prev   = num_in;
            assign zero_prev  = (sum_in == '0);
         end else begin : g_next
            assign valid_prev = valid_ff[j-1];
            assign rad_prev   = rad_ff[j-1];
            assign rem_prev   = rem_ff[j-1];
            assign root_prev  = root_ff[j-1];
            assign num_prev   = num_ff[j-1];
            assign zero_prev  = zero_ff[j-1];
         end

         // bring down the next two radicand bits; the low ones are the preshift zeros
         if (2 * K >= SQRT_PRE) begin : g_pair
            assign pair = rad_prev[2*K-SQRT_PRE +: 2];
         end else begin : g_zero
            assign pair = 2'b00;
         end

         always_comb begin
            rem_sh = {rem_prev[REM_W-3:0], pair};
            trial  = {2'b00, root_prev, 2'b01};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_prev[ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j] <= 1'b0;
            end else if (en) begin
               valid_ff[j] <= valid_prev;
            end
            if (en) begin
               rad_ff[j]  <= rad_prev;
               rem_ff[j]  <= rem_in;
               root_ff[j] <= root_in;
               num_ff[j]  <= num_prev;
               zero_ff[j] <= zero_prev;
            end
         end
      end
   endgenerate

   assign valid_out = valid_ff[ROOT_W-1];
   assign root_out  = root_ff[ROOT_W-1];
   assign num_out   = num_ff[ROOT_W-1];
   assign zero_out  = zero_ff[ROOT_W-1];

endmodule

/* hdl/atrp_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_norm: vector normalizer
// Builds the CORDIC start vector and scales it up until its larger side
// reaches 2^40, in binary shift steps of 16, 8, 4, 2 and 1.
// ----------------------------------------------------------------------------
module atrp_norm import atrp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     valid_in,
   input  logic [ROOT_W-1:0]        root_in,
   input  logic signed [CORR_W-1:0] num_in,
   input  logic                     zero_in,
   output logic                     valid_out,
   output logic signed [VEC_W-1:0]  vx_out,
   output logic signed [VEC_W-1:0]  vy_out,
   output logic                     zero_out
);

   logic                    valid_ff [NORM_STEPS+1];
   logic [NORM_W-1:0]       mag_ff   [NORM_STEPS+1];
   logic signed [VEC_W-1:0] vx_ff    [NORM_STEPS+1];
   logic signed [VEC_W-1:0] vy_ff    [NORM_STEPS+1];
   logic                    zero_ff  [NORM_STEPS+1];

   logic [CORR_W-1:0] num_abs;
   logic [NORM_W-1:0] mag_x;
   logic [NORM_W-1:0] mag_y;

   always_comb begin
      num_abs = num_in[CORR_W-1] ? CORR_W'(-num_in) : CORR_W'(num_in);
      mag_x   = NORM_W'(root_in);
      mag_y   = NORM_W'({num_abs, {VY_SHIFT{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= valid_in;
      end
      if (en) begin
         mag_ff[0]  <= (mag_x > mag_y) ? mag_x : mag_y;
         vx_ff[0]   <= VEC_W'(signed'({1'b0, root_in}));
         vy_ff[0]   <= VEC_W'(signed'({num_in, {VY_SHIFT{1'b0}}}));
         zero_ff[0] <= zero_in;
      end
   end

   genvar j;
   generate
      for (j = 0; j < NORM_STEPS; j++) begin : g_step
         localparam int D = 1 << (NORM_STEPS - 1 - j);
         logic fits;

         // shift only while the larger side stays below 2^41
         assign fits = ((mag_ff[j] >> (NORM_W - D)) == '0);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j+1] <= 1'b0;
            end else if (en) begin
               valid_ff[j+1] <= valid_ff[j];
            end
            if (en) begin
               mag_ff[j+1]  <= fits ? (mag_ff[j] << D) : mag_ff[j];
               vx_ff[j+1]   <= fits ? (vx_ff[j] <<< D) : vx_ff[j];
               vy_ff[j+1]   <= fits ? (vy_ff[j] <<< D) : vy_ff[j];
               zero_ff[j+1] <= zero_ff[j];
            end
         end
      end
   endgenerate

   assign valid_out = valid_ff[NORM_STEPS];
   assign vx_out    = vx_ff[NORM_STEPS];
   assign vy_out    = vy_ff[NORM_STEPS];
   assign zero_out  = zero_ff[NORM_STEPS];

endmodule

/* hdl/atrp_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_cordic: pipelined vectoring CORDIC with output rounding
// One micro-rotation per stage, then round, saturate to 90 degrees, pack.
// ----------------------------------------------------------------------------
module atrp_cordic import atrp_pkg::*;
#(
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      valid_in,
   input  logic signed [VEC_W-1:0]   vx_in,
   input  logic signed [VEC_W-1:0]   vy_in,
   input  logic                      zero_in,
   output logic                      valid_out,
   output logic signed [ANGLE_W-1:0] angle_out
);

   localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SH - 1);
   localparam logic [ACC_W-1:0] CAP  = ACC_W'(CAP_DEG) << ANGLE_FRAC_BITS;

   logic                    valid_ff [CORDIC_STAGES];
   logic signed [VEC_W-1:0] vx_ff    [CORDIC_STAGES];
   logic signed [VEC_W-1:0] vy_ff    [CORDIC_STAGES];
   logic signed [ACC_W-1:0] z_ff     [CORDIC_STAGES];
   logic                    zero_ff  [CORDIC_STAGES];

   genvar j;
   generate
      for (j = 0; j < CORDIC_STAGES; j++) begin : g_rot
         logic                    valid_prev;
         logic signed [VEC_W-1:0] vx_prev;
         logic signed [VEC_W-1:0] vy_prev;
         logic signed [ACC_W-1:0] z_prev;
         logic                    zero_prev;
         logic signed [VEC_W-1:0] dx;
         logic signed [VEC_W-1:0] dy;
         logic signed [ACC_W-1:0] step;

         if (j == 0) begin : g_first
            assign valid_prev = valid_in;
            assign vx_prev    = vx_in;
            assign vy_prev    = vy_in;
            assign z_prev     = '0;
            assign zero_prev  = zero_in;
         end else begin : g_next
            assign valid_prev = valid_ff[j-1];
            assign vx_prev    = vx_ff[j-1];
            assign vy_prev    = vy_ff[j-1];
            assign z_prev     = z_ff[j-1];
            assign zero_prev  = zero_ff[j-1];
         end

         assign dx   = vy_prev >>> j;
         assign dy   = vx_prev >>> j;
         assign step = signed'(ACC_W'(ATAN_TAB[j]));

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j] <= 1'b0;
            end else if (en) begin
               valid_ff[j] <= valid_prev;
            end
            if (en) begin
               // rotate toward the x axis
               if (!vy_prev[VEC_W-1]) begin
                  vx_ff[j] <= vx_prev + dx;
                  vy_ff[j] <= vy_prev - dy;
                  z_ff[j]  <= z_prev + step;
               end else begin
                  vx_ff[j] <= vx_prev - dx;
                  vy_ff[j] <= vy_prev + dy;
                  z_ff[j]  <= z_prev - step;
               end
               zero_ff[j] <= zero_prev;
            end
         end
      end
   endgenerate

   logic                      neg;
   logic [ACC_W-1:0]          z_abs;
   logic [ACC_W-1:0]          q_round;
   logic [ACC_W-1:0]          q_cap;
   logic [ACC_W-1:0]          q_sign;
   logic                      valid_out_ff;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic signed [ANGLE_W-1:0] angle_in;

   // round half away from zero on the magnitude, then cap and restore sign
   always_comb begin
      neg      = z_ff[CORDIC_STAGES-1][ACC_W-1];
      z_abs    = neg ? ACC_W'(-z_ff[CORDIC_STAGES-1]) : ACC_W'(z_ff[CORDIC_STAGES-1]);
      q_round  = (z_abs + HALF) >> SH;
      q_cap    = (q_round > CAP) ? CAP : q_round;
      q_sign   = neg ? (~q_cap + ACC_W'(1)) : q_cap;
      angle_in = zero_ff[CORDIC_STAGES-1] ? '0 : signed'(q_sign[ANGLE_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else if (en) begin
         valid_out_ff <= valid_ff[CORDIC_STAGES-1];
      end
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign valid_out = valid_out_ff;
   assign angle_out = angle_ff;

endmodule

/* hdl/atrp_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_angle: one tilt angle path
// atan(num / sqrt(sum)) through root, normalizer and CORDIC pipelines.
// ----------------------------------------------------------------------------
module atrp_angle import atrp_pkg::*;
#(
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      valid_in,
   input  logic [SUM_W-1:0]          sum_in,
   input  logic signed [CORR_W-1:0]  num_in,
   output logic                      valid_out,
   output logic signed [ANGLE_W-1:0] angle_out
);

   logic                     sq_valid;
   logic [ROOT_W-1:0]        sq_root;
   logic signed [CORR_W-1:0] sq_num;
   logic                     sq_zero;
   logic                     nm_valid;
   logic signed [VEC_W-1:0]  nm_vx;
   logic signed [VEC_W-1:0]  nm_vy;
   logic                     nm_zero;

   atrp_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (valid_in),
      .sum_in    (sum_in),
      .num_in    (num_in),
      .valid_out (sq_valid),
      .root_out  (sq_root),
      .num_out   (sq_num),
      .zero_out  (sq_zero)
   );

   atrp_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (sq_valid),
      .root_in   (sq_root),
      .num_in    (sq_num),
      .zero_in   (sq_zero),
      .valid_out (nm_valid),
      .vx_out    (nm_vx),
      .vy_out    (nm_vy),
      .zero_out  (nm_zero)
   );

   atrp_cordic #(
      .CORDIC_STAGES   (CORDIC_STAGES),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (nm_valid),
      .vx_in     (nm_vx),
      .vy_in     (nm_vy),
      .zero_in   (nm_zero),
      .valid_out (valid_out),
      .angle_out (angle_out)
   );

endmodule

/* hdl/accel_tilt_roll_pitch.sv */
`timescale 1ns / 1ps
// Pipeline: offset, square and sum registers, then the root, normalizer and
//   CORDIC stages (one root bit and one micro-rotation per stage) and an output register.
// Throughput: one sample per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous, clears all valid bits and loads the default offsets.
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch: roll and pitch from a three-axis accelerometer
// Subtracts calibration offsets, forms the sums of squares and runs two
// parallel root / normalize / CORDIC paths for roll and pitch.
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch import atrp_pkg::*;
#(
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   atrp_req_if.sink               req_if,
   atrp_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic signed [AXIS_W-1:0] off_x_ff;
   logic signed [AXIS_W-1:0] off_y_ff;
   logic signed [AXIS_W-1:0] off_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= OFFSET_X_RST;
         off_y_ff <= OFFSET_Y_RST;
         off_z_ff <= OFFSET_Z_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_X: off_x_ff <= signed'(csr_wdata);
            CSR_OFFSET_Y: off_y_ff <= signed'(csr_wdata);
            CSR_OFFSET_Z: off_z_ff <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   logic en;
   logic roll_valid;

   // advance everything unless the output item is held
   assign en           = !roll_valid || rsp_if.ready;
   assign req_if.ready = en;

   logic                     s0_valid_ff;
   logic signed [CORR_W-1:0] x_ff;
   logic signed [CORR_W-1:0] y_ff;
   logic signed [CORR_W-1:0] z_ff;
   logic                     s1_valid_ff;
   logic [SQ_W-1:0]          xx_ff;
   logic [SQ_W-1:0]          yy_ff;
   logic [SQ_W-1:0]          zz_ff;
   logic signed [CORR_W-1:0] x1_ff;
   logic signed [CORR_W-1:0] y1_ff;
   logic                     s2_valid_ff;
   logic [SUM_W-1:0]         sum_r_ff;
   logic [SUM_W-1:0]         sum_p_ff;
   logic signed [CORR_W-1:0] num_r_ff;
   logic signed [CORR_W-1:0] num_p_ff;

   logic signed [2*CORR_W-1:0] xx_full;
   logic signed [2*CORR_W-1:0] yy_full;
   logic signed [2*CORR_W-1:0] zz_full;

   always_comb begin
      xx_full = x_ff * x_ff;
      yy_full = y_ff * y_ff;
      zz_full = z_ff * z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_if.valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         x_ff <= CORR_W'(req_if.accel_x) - CORR_W'(off_x_ff);
         y_ff <= CORR_W'(req_if.accel_y) - CORR_W'(off_y_ff);
         z_ff <= CORR_W'(req_if.accel_z) - CORR_W'(off_z_ff);

         xx_ff <= xx_full[SQ_W-1:0];
         yy_ff <= yy_full[SQ_W-1:0];
         zz_ff <= zz_full[SQ_W-1:0];
         x1_ff <= x_ff;
         y1_ff <= y_ff;

         sum_r_ff <= SUM_W'(xx_ff) + SUM_W'(zz_ff);
         sum_p_ff <= SUM_W'(yy_ff) + SUM_W'(zz_ff);
         num_r_ff <= y1_ff;
         num_p_ff <= -x1_ff;
      end
   end

   atrp_angle #(
      .CORDIC_STAGES   (CORDIC_STAGES),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (s2_valid_ff),
      .sum_in    (sum_r_ff),
      .num_in    (num_r_ff),
      .valid_out (roll_valid),
      .angle_out (rsp_if.roll_angle)
   );

   // same latency as roll; its valid copy is not needed
   atrp_angle #(
      .CORDIC_STAGES   (CORDIC_STAGES),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (s2_valid_ff),
      .sum_in    (sum_p_ff),
      .num_in    (num_p_ff),
      .valid_out (),
      .angle_out (rsp_if.pitch_angle)
   );

   assign rsp_if.valid = roll_valid;

endmodule
